[rtl/core/mf3_pkg.sv]
// Shared types and constants for the 3x3 median filter core.
// Used by the line store, window cells, median network and top level.
// No dependencies.
package mf3_pkg;

   localparam int PixelW      = 8;
   localparam int CsrDataW    = 11;
   localparam int HeightW     = 11;
   localparam int RowW        = 10;
   localparam int HeightLimit = 1024;

   typedef logic [PixelW-1:0] pixel_type;
   typedef pixel_type [8:0] pix9_type;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      pixel_type two_above;
      pixel_type above;
   } line_entry_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } edge_mask_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

endpackage

[rtl/core/mf3_line_store.sv]
// Dual line store: one entry per column holds the two previous rows.
// One write port and one registered read port.
// Depends on mf3_pkg.
module mf3_line_store #(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output mf3_pkg::line_entry_type rd_data,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  mf3_pkg::line_entry_type wr_data
);

   mf3_pkg::line_entry_type mem [DEPTH];
   mf3_pkg::line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mf3_col_cell.sv]
// One column of the 3x3 window; cells chain left to right and
// pass their column to the left neighbor on each shift. Depends on mf3_pkg.
module mf3_col_cell (
   input  logic                clock,
   input  logic                shift,
   input  mf3_pkg::column_type col_in,
   output mf3_pkg::column_type col_out
);

   mf3_pkg::column_type col_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule

[rtl/core/mf3_median9.sv]
// Median of nine pixels: 19 compare-exchanges in three registered stages.
// Depends on mf3_pkg.
module mf3_median9 (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  mf3_pkg::tag_type    in_tag,
   input  mf3_pkg::pix9_type   in_pix,
   output mf3_pkg::tag_type    out_tag,
   output mf3_pkg::pixel_type  out_median
);

   function automatic mf3_pkg::pix9_type cx(input mf3_pkg::pix9_type p,
                                            input logic [3:0] a,
                                            input logic [3:0] b);
      mf3_pkg::pix9_type q;
      q = p;
      if (p[a] > p[b]) begin
         q[a] = p[b];
         q[b] = p[a];
      end
      return q;
   endfunction

   mf3_pkg::pix9_type  a_pix_in;
   mf3_pkg::pix9_type  a_pix_ff;
   mf3_pkg::pix9_type  b_pix_in;
   mf3_pkg::pix9_type  b_pix_ff;
   mf3_pkg::pix9_type  c_pix_in;
   mf3_pkg::pixel_type med_ff;
   mf3_pkg::tag_type   a_tag_ff;
   mf3_pkg::tag_type   b_tag_ff;
   mf3_pkg::tag_type   c_tag_ff;

   always_comb begin
      a_pix_in = in_pix;
      a_pix_in = cx(a_pix_in, 4'd1, 4'd2);
      a_pix_in = cx(a_pix_in, 4'd4, 4'd5);
      a_pix_in = cx(a_pix_in, 4'd7, 4'd8);
      a_pix_in = cx(a_pix_in, 4'd0, 4'd1);
      a_pix_in = cx(a_pix_in, 4'd3, 4'd4);
      a_pix_in = cx(a_pix_in, 4'd6, 4'd7);
      a_pix_in = cx(a_pix_in, 4'd1, 4'd2);
      a_pix_in = cx(a_pix_in, 4'd4, 4'd5);
      a_pix_in = cx(a_pix_in, 4'd7, 4'd8);
   end

   always_comb begin
      b_pix_in = a_pix_ff;
      b_pix_in = cx(b_pix_in, 4'd0, 4'd3);
      b_pix_in = cx(b_pix_in, 4'd5, 4'd8);
      b_pix_in = cx(b_pix_in, 4'd4, 4'd7);
      b_pix_in = cx(b_pix_in, 4'd3, 4'd6);
      b_pix_in = cx(b_pix_in, 4'd1, 4'd4);
      b_pix_in = cx(b_pix_in, 4'd2, 4'd5);
      b_pix_in = cx(b_pix_in, 4'd4, 4'd7);
   end

   always_comb begin
      c_pix_in = b_pix_ff;
      c_pix_in = cx(c_pix_in, 4'd4, 4'd2);
      c_pix_in = cx(c_pix_in, 4'd6, 4'd4);
      c_pix_in = cx(c_pix_in, 4'd4, 4'd2);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_pix_ff <= a_pix_in;
         b_pix_ff <= b_pix_in;
         med_ff   <= c_pix_in[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         b_tag_ff <= '0;
         c_tag_ff <= '0;
      end else if (advance) begin
         a_tag_ff <= in_tag;
         b_tag_ff <= a_tag_ff;
         c_tag_ff <= b_tag_ff;
      end
   end

   assign out_tag    = c_tag_ff;
   assign out_median = med_ff;

endmodule

[rtl/core/median_filter_3x3_core.sv]
// 3x3 median filter core: top level with stream ports, counters and output skid.
// Depends on mf3_pkg, mf3_line_store, mf3_col_cell and mf3_median9.
//
// Takes one 8-bit grey pixel per clock in raster order and returns the median of its
// zero-padded 3x3 neighborhood, one request per clock sustained while the skid entry
// is empty. Results lag the input stream by image_width+1 requests, so after the last
// pixel of a frame send image_width+1 drain requests (tuser = 1); the last result
// carries tlast. A request passes the line store read, the window with its edge mask,
// three median stages and the output register; throughput is set by the line store,
// read and written once per request. A two-entry output buffer keeps the request side
// moving while one result waits. Register writes (index 0 width, index 1 height)
// restart the frame and are taken any time the core is idle.
module median_filter_3x3_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic        req_tuser,   // [0] op: drain step
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] filtered_pixel
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int EW = (AW + 1 > 12) ? AW + 1 : 12;
   localparam int HW = mf3_pkg::HeightW;
   localparam int RW = mf3_pkg::RowW;

   logic [mf3_pkg::CsrDataW-1:0] image_width_ff, image_width_in;
   logic [mf3_pkg::CsrDataW-1:0] image_height_ff, image_height_in;
   logic [AW-1:0] in_col_ff, in_col_in;
   logic          row_past0_ff, row_past0_in;
   logic          row_past1_ff, row_past1_in;
   logic [AW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;

   logic [EW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic          advance;
   logic          accept;
   logic          in_col_wrap;
   logic          out_col_wrap;
   logic          emit;
   logic          last;
   mf3_pkg::edge_mask_type mask;
   mf3_pkg::pixel_type     new_pix;

   logic                    s1_valid_ff;
   logic [AW-1:0]           s1_col_ff;
   mf3_pkg::pixel_type      s1_pix_ff;
   logic                    s1_emit_ff;
   logic                    s1_last_ff;
   mf3_pkg::edge_mask_type  s1_mask_ff;
   logic                    byp_hit_ff;
   mf3_pkg::line_entry_type byp_data_ff;
   mf3_pkg::line_entry_type rd_entry;
   mf3_pkg::line_entry_type cur_entry;
   mf3_pkg::line_entry_type wr_entry;
   mf3_pkg::column_type     new_col;
   mf3_pkg::column_type     win_col [3];
   logic                    shift;

   mf3_pkg::tag_type        s2_tag_ff;
   mf3_pkg::edge_mask_type  s2_mask_ff;
   mf3_pkg::pix9_type       win_pix;
   mf3_pkg::tag_type        med_tag;
   mf3_pkg::pixel_type      med_pix;

   logic                    out_valid_ff;
   mf3_pkg::pixel_type      out_pix_ff;
   logic                    out_last_ff;
   logic                    skid_valid_ff;
   mf3_pkg::pixel_type      skid_pix_ff;
   logic                    skid_last_ff;
   logic                    take;

   assign advance    = !skid_valid_ff;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign csr_ready  = 1'b1;
   assign new_pix    = req_tuser ? '0 : req_tdata;

   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = EW'(1);
      end else if (EW'(image_width_ff) > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = EW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         h_eff = HW'(1);
      end else if (image_height_ff > HW'(mf3_pkg::HeightLimit)) begin
         h_eff = HW'(mf3_pkg::HeightLimit);
      end else begin
         h_eff = image_height_ff;
      end
   end

   assign in_col_wrap  = EW'(in_col_ff) == w_eff - EW'(1);
   assign out_col_wrap = EW'(out_col_ff) == w_eff - EW'(1);
   assign emit         = row_past1_ff || (row_past0_ff && in_col_ff != '0);
   assign mask.top     = out_row_ff == '0;
   assign mask.bottom  = HW'(out_row_ff) == h_eff - HW'(1);
   assign mask.left    = out_col_ff == '0;
   assign mask.right   = out_col_wrap;
   assign last         = mask.bottom && mask.right;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      in_col_in       = in_col_ff;
      row_past0_in    = row_past0_ff;
      row_past1_in    = row_past1_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      if (csr_valid) begin
         case (mf3_pkg::csr_index_type'(csr_index))
            mf3_pkg::CSR_IMAGE_WIDTH:  image_width_in  = csr_data;
            mf3_pkg::CSR_IMAGE_HEIGHT: image_height_in = csr_data;
            default: ;
         endcase
         in_col_in    = '0;
         row_past0_in = 1'b0;
         row_past1_in = 1'b0;
         out_col_in   = '0;
         out_row_in   = '0;
      end else if (accept) begin
         if (in_col_wrap) begin
            in_col_in    = '0;
            row_past0_in = 1'b1;
            row_past1_in = row_past0_ff;
         end else begin
            in_col_in = in_col_ff + AW'(1);
         end
         if (emit) begin
            if (last) begin
               in_col_in    = '0;
               row_past0_in = 1'b0;
               row_past1_in = 1'b0;
               out_col_in   = '0;
               out_row_in   = '0;
            end else if (out_col_wrap) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= mf3_pkg::CsrDataW'(256);
         image_height_ff <= mf3_pkg::CsrDataW'(256);
         in_col_ff       <= '0;
         row_past0_ff    <= 1'b0;
         row_past1_ff    <= 1'b0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         in_col_ff       <= in_col_in;
         row_past0_ff    <= row_past0_in;
         row_past1_ff    <= row_past1_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
      end
   end

   // stage 1: line store read returns, window column forms
   assign cur_entry          = byp_hit_ff ? byp_data_ff : rd_entry;
   assign new_col.top        = cur_entry.two_above;
   assign new_col.mid        = cur_entry.above;
   assign new_col.bot        = s1_pix_ff;
   assign wr_entry.two_above = cur_entry.above;
   assign wr_entry.above     = s1_pix_ff;
   assign shift              = advance && s1_valid_ff;

   mf3_line_store #(
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .rd_data (rd_entry),
      .wr_en   (shift),
      .wr_addr (s1_col_ff),
      .wr_data (wr_entry)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_col_ff   <= in_col_ff;
         s1_pix_ff   <= new_pix;
         s1_emit_ff  <= emit;
         s1_last_ff  <= last;
         s1_mask_ff  <= mask;
         byp_hit_ff  <= s1_valid_ff && (s1_col_ff == in_col_ff);
         byp_data_ff <= wr_entry;
         s2_mask_ff  <= s1_mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_tag_ff   <= '0;
      end else if (advance) begin
         s1_valid_ff     <= accept;
         s2_tag_ff.valid <= s1_valid_ff && s1_emit_ff;
         s2_tag_ff.last  <= s1_last_ff;
      end
   end

   mf3_col_cell u_cell_right (
      .clock   (clock),
      .shift   (shift),
      .col_in  (new_col),
      .col_out (win_col[2])
   );

   mf3_col_cell u_cell_center (
      .clock   (clock),
      .shift   (shift),
      .col_in  (win_col[2]),
      .col_out (win_col[1])
   );

   mf3_col_cell u_cell_left (
      .clock   (clock),
      .shift   (shift),
      .col_in  (win_col[1]),
      .col_out (win_col[0])
   );

   // stage 2: zero the neighbors outside the image
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         win_pix[j]     = (s2_mask_ff.top ||
                           (j == 0 && s2_mask_ff.left) ||
                           (j == 2 && s2_mask_ff.right)) ? '0 : win_col[j].top;
         win_pix[3 + j] = ((j == 0 && s2_mask_ff.left) ||
                           (j == 2 && s2_mask_ff.right)) ? '0 : win_col[j].mid;
         win_pix[6 + j] = (s2_mask_ff.bottom ||
                           (j == 0 && s2_mask_ff.left) ||
                           (j == 2 && s2_mask_ff.right)) ? '0 : win_col[j].bot;
      end
   end

   mf3_median9 u_median9 (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_tag     (s2_tag_ff),
      .in_pix     (win_pix),
      .out_tag    (med_tag),
      .out_median (med_pix)
   );

   // output register with one skid entry
   assign take = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (med_tag.valid) begin
         if (out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_pix_ff  <= skid_pix_ff;
            out_last_ff <= skid_last_ff;
         end
      end else if (med_tag.valid) begin
         if (out_valid_ff && !take) begin
            skid_pix_ff  <= med_pix;
            skid_last_ff <= med_tag.last;
         end else begin
            out_pix_ff  <= med_pix;
            out_last_ff <= med_tag.last;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[test/tb_median_filter_3x3_core.sv]
// Self-checking testbench for median_filter_3x3_core: drives pixel and drain requests,
// predicts each zero-padded 3x3 median and checks every response in order.
// Depends on mf3_pkg and the median_filter_3x3_core RTL.
module tb_median_filter_3x3_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mf3_pkg::*;

   localparam int MaxWidth = 1024;
   localparam int SettleCycles = 16;
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;
   localparam int MODE_UNIFORM = 0;
   localparam int MODE_EXTREME = 1;
   localparam int MODE_SALT_PEPPER = 2;
   localparam int NO_PAUSE = -1;

   typedef struct packed {
      logic      last;
      pixel_type value;
   } median_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] pixel
   logic        req_tuser = 1'b0; // [0] op: drain step
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] filtered_pixel
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [10:0] csr_data = '0;

   median_type  pending_medians[$];
   pixel_type   prev_line [MaxWidth];
   pixel_type   prev2_line [MaxWidth];
   pixel_type   win_cells [9];
   logic [10:0] width_reg;
   logic [10:0] height_reg;
   int unsigned row_pos;
   int unsigned col_pos;
   int unsigned result_idx;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int failures = 0;
   int requests_sent = 0;
   int results_seen = 0;
   int register_writes = 0;

   median_filter_3x3_core #(.MAX_WIDTH(MaxWidth)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin : check_medians
      median_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_medians.size() == 0) begin
            $error("unexpected response: filtered_pixel %0d, frame_last %0b",
                   rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            want = pending_medians.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("filtered_pixel: expected %0d, got %0d", want.value, rsp_tdata);
               failures++;
            end
            if (rsp_tlast !== want.last) begin
               $error("frame_last: expected %0b, got %0b", want.last, rsp_tlast);
               failures++;
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic pixel_type pick_pixel(input int mode);
      int unsigned r;
      r = $urandom_range(0, 9);
      case (mode)
         MODE_EXTREME: begin
            return (r < 5) ? 8'd0 : 8'd255;
         end
         MODE_SALT_PEPPER: begin
            if (r == 0) return 8'd0;
            if (r == 1) return 8'd255;
            return 8'(100 + $urandom_range(0, 40));
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   task automatic restart_frame_model();
      row_pos = 0;
      col_pos = 0;
      result_idx = 0;
   endtask

   task automatic compute_median_step(input logic op, input pixel_type pix);
      int unsigned w, h, col, n, crow, ccol;
      pixel_type   incoming, top, mid, tmp;
      pixel_type   hood [9];
      median_type  m;
      w = clamp_dim(width_reg, MaxWidth);
      h = clamp_dim(height_reg, HeightLimit);
      col = col_pos % MaxWidth;
      incoming = (op == OP_DRAIN) ? 8'd0 : pix;
      top = prev2_line[col];
      mid = prev_line[col];
      n = row_pos * w + col_pos;
      for (int k = 0; k < 3; k++) begin
         win_cells[k*3] = win_cells[k*3+1];
         win_cells[k*3+1] = win_cells[k*3+2];
      end
      win_cells[2] = top;
      win_cells[5] = mid;
      win_cells[8] = incoming;
      prev2_line[col] = mid;
      prev_line[col] = incoming;
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (n < w + 1) return;
      crow = result_idx / w;
      ccol = result_idx % w;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if ((i == 0 && crow == 0) || (i == 2 && crow >= h - 1) ||
                (j == 0 && ccol == 0) || (j == 2 && ccol == w - 1))
               hood[i*3+j] = 8'd0;
            else
               hood[i*3+j] = win_cells[i*3+j];
         end
      end
      for (int a = 0; a < 8; a++) begin
         for (int b = 0; b < 8 - a; b++) begin
            if (hood[b] > hood[b+1]) begin
               tmp = hood[b];
               hood[b] = hood[b+1];
               hood[b+1] = tmp;
            end
         end
      end
      m.value = hood[4];
      m.last = (result_idx >= w * h - 1);
      pending_medians.push_back(m);
      if (m.last) restart_frame_model();
      else result_idx++;
   endtask

   task automatic send_request(input logic op, input pixel_type pix);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      compute_median_step(op, pix);
      requests_sent++;
   endtask

   task automatic wait_for_medians();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_medians.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [10:0] value);
      wait_for_medians();
      repeat (SettleCycles) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
      restart_frame_model();
      register_writes++;
   endtask

   task automatic set_geometry(input logic [10:0] w, input logic [10:0] h);
      write_register(CSR_IMAGE_WIDTH, w);
      write_register(CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic run_frame(input logic [10:0] w, input logic [10:0] h, input int mode,
                            input int pause_at);
      int unsigned ew, total;
      ew = clamp_dim(w, MaxWidth);
      total = ew * clamp_dim(h, HeightLimit);
      for (int i = 0; i < total; i++) begin
         if (i == pause_at) wait_for_medians();
         send_request(OP_PIXEL, pick_pixel(mode));
      end
      repeat (ew + 1) send_request(OP_DRAIN, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_reset_geometry();
      repeat (300) send_request(OP_PIXEL, pick_pixel(MODE_UNIFORM));
   endtask

   task automatic test_small_frames();
      set_geometry(11'd3, 11'd3);
      run_frame(11'd3, 11'd3, MODE_EXTREME, 5);
      set_geometry(11'd0, 11'd0);
      run_frame(11'd0, 11'd0, MODE_UNIFORM, NO_PAUSE);
      set_geometry(11'd2, 11'd2);
      send_request(OP_PIXEL, 8'd255);
      send_request(OP_DRAIN, 8'd255);
      send_request(OP_PIXEL, 8'h5A);
      send_request(OP_PIXEL, 8'hA5);
      send_request(OP_PIXEL, 8'hFF);
      send_request(OP_DRAIN, 8'h00);
      send_request(OP_DRAIN, 8'h00);
   endtask

   task automatic test_size_extremes();
      set_geometry(11'd2047, 11'd2047);
      repeat (MaxWidth + 8) send_request(OP_PIXEL, pick_pixel(MODE_SALT_PEPPER));
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall, input int count);
      int          start;
      bit          geometry_ok;
      logic [10:0] w, h;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      start = requests_sent;
      geometry_ok = 1'b0;
      w = 11'd4;
      h = 11'd4;
      while (requests_sent - start < count) begin
         if ($urandom_range(0, 9) < 8) begin
            if (!geometry_ok || $urandom_range(0, 2) == 0) begin
               w = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2))
                                                : 11'($urandom_range(3, 12));
               h = 11'($urandom_range(0, 8));
               set_geometry(w, h);
            end
            run_frame(w, h, $urandom_range(0, 2),
                      ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 8)) : NO_PAUSE);
            geometry_ok = 1'b1;
         end else begin
            repeat ($urandom_range(1, 40))
               send_request(($urandom_range(0, 3) == 0) ? OP_DRAIN : OP_PIXEL,
                            pick_pixel(MODE_UNIFORM));
            geometry_ok = 1'b0;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < MaxWidth; i++) begin
         prev_line[i] = '0;
         prev2_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win_cells[i] = '0;
      width_reg = 11'd256;
      height_reg = 11'd256;
      restart_frame_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_geometry();
      test_small_frames();
      test_size_extremes();
      test_random_traffic(0, 0, 70);
      test_random_traffic(76, 0, 70);
      test_random_traffic(0, 76, 70);
      test_random_traffic(11, 11, 70);

      wait_for_medians();
      repeat (SettleCycles) @(posedge clock);
      $display("Covered %0d requests, %0d responses and %0d register writes,",
               requests_sent, results_seen, register_writes);
      $display("frames from 1x1 to 12x8, a clamped 1024-pixel row, early drains,");
      $display("extra pixels and cut frames.");
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
